>>> hdl/ccds_pkg.sv
// Shared types, constants and functions for the clock/calendar display scan unit.
package ccds_pkg;

	localparam int unsigned CPS_W = 12;
	localparam logic [CPS_W-1:0] CPS_RESET = 12'd244;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [13:0] YEAR_RESET = 14'd2018;
	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	// year mod 100 and mod 400 at reset
	localparam logic [6:0] YEAR_M100_RESET = 7'd18;
	localparam logic [8:0] YEAR_M400_RESET = 9'd18;

	// BCD time and calendar date
	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [1:0]  hr_t;
		logic [3:0]  hr_u;
		logic [2:0]  min_t;
		logic [3:0]  min_u;
		logic [2:0]  sec_t;
		logic [3:0]  sec_u;
	} time_t;

	localparam time_t TIME_RESET = '{
		year: YEAR_RESET, month: MONTH_DEC, day: 5'd1,
		hr_t: 2'd0, hr_u: 4'd0, min_t: 3'd0, min_u: 4'd0, sec_t: 3'd0, sec_u: 4'd0
	};

	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0:    seg = 8'hFC;
			4'd1:    seg = 8'h60;
			4'd2:    seg = 8'hDA;
			4'd3:    seg = 8'hF2;
			4'd4:    seg = 8'h66;
			4'd5:    seg = 8'hB6;
			4'd6:    seg = 8'hBE;
			4'd7:    seg = 8'hE4;
			4'd8:    seg = 8'hFE;
			4'd9:    seg = 8'hF6;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		logic [4:0] days;
		case (month) inside
			MONTH_FEB:                               days = leap ? 5'd29 : 5'd28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
			default:                                 days = 5'd31;
		endcase
		return days;
	endfunction

endpackage

>>> hdl/ccds_time_core.sv
// Scan phase, half-tick counter and BCD time/date counters.
module ccds_time_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick,
	input  logic [ccds_pkg::CPS_W-1:0]    cps,
	output logic [1:0]                    phase_nxt,
	output ccds_pkg::time_t               time_cur,
	output ccds_pkg::time_t               time_nxt
);

	logic [1:0]                 phase_q;
	logic [ccds_pkg::CPS_W-1:0] half_cnt_q;
	logic [ccds_pkg::CPS_W-1:0] half_inc;
	logic [ccds_pkg::CPS_W-1:0] half_nxt;
	ccds_pkg::time_t            time_q;
	logic [6:0]                 m100_q, m100_nxt;
	logic [8:0]                 m400_q, m400_nxt;
	logic                       count_en, sec_step;
	logic                       c_sec_u, c_sec_t, c_min_u, c_min_t, c_day;
	logic                       midnight, month_end, year_end, year_inc, leap;
	logic [3:0]                 hr_u_inc;
	logic [1:0]                 hr_t_inc;

	assign time_cur = time_q;

	// year mod 4/100/400 tracked incrementally, no divider
	assign leap = ((time_q.year[1:0] == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);

	always_comb begin
		phase_nxt = phase_q + 2'd1;
		count_en  = ~phase_nxt[0];          // phases 0 and 2
		half_inc  = half_cnt_q + {{(ccds_pkg::CPS_W-1){1'b0}}, 1'b1};
		sec_step  = count_en && (half_inc >= cps);
		half_nxt  = count_en ? (sec_step ? '0 : half_inc) : half_cnt_q;

		c_sec_u = sec_step && (time_q.sec_u == 4'd9);
		c_sec_t = c_sec_u && (time_q.sec_t == 3'd5);
		c_min_u = c_sec_t && (time_q.min_u == 4'd9);
		c_min_t = c_min_u && (time_q.min_t == 3'd5);

		hr_u_inc = (time_q.hr_u == 4'd9) ? 4'd0 : time_q.hr_u + 4'd1;
		hr_t_inc = (time_q.hr_u == 4'd9) ? time_q.hr_t + 2'd1 : time_q.hr_t;
		midnight = (hr_t_inc == 2'd2) && (hr_u_inc == 4'd4);

		c_day     = c_min_t && midnight;
		month_end = time_q.day >= ccds_pkg::days_in_month(time_q.month, leap);
		year_end  = time_q.month == ccds_pkg::MONTH_DEC;
		year_inc  = c_day && month_end && year_end && (time_q.year < ccds_pkg::YEAR_MAX);

		time_nxt = time_q;
		if (sec_step)
			time_nxt.sec_u = c_sec_u ? 4'd0 : time_q.sec_u + 4'd1;
		if (c_sec_u)
			time_nxt.sec_t = c_sec_t ? 3'd0 : time_q.sec_t + 3'd1;
		if (c_sec_t)
			time_nxt.min_u = c_min_u ? 4'd0 : time_q.min_u + 4'd1;
		if (c_min_u)
			time_nxt.min_t = c_min_t ? 3'd0 : time_q.min_t + 3'd1;
		if (c_min_t) begin
			time_nxt.hr_u = midnight ? 4'd0 : hr_u_inc;
			time_nxt.hr_t = midnight ? 2'd0 : hr_t_inc;
		end
		if (c_day) begin
			time_nxt.day = month_end ? 5'd1 : time_q.day + 5'd1;
			if (month_end)
				time_nxt.month = year_end ? ccds_pkg::MONTH_JAN : time_q.month + 4'd1;
		end
		if (year_inc)
			time_nxt.year = time_q.year + 14'd1;

		m100_nxt = m100_q;
		m400_nxt = m400_q;
		if (year_inc) begin
			m100_nxt = (m100_q == 7'd99)  ? 7'd0 : m100_q + 7'd1;
			m400_nxt = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 2'd0;
			half_cnt_q <= '0;
			time_q     <= ccds_pkg::TIME_RESET;
			m100_q     <= ccds_pkg::YEAR_M100_RESET;
			m400_q     <= ccds_pkg::YEAR_M400_RESET;
		end else if (tick) begin
			phase_q    <= phase_nxt;
			half_cnt_q <= half_nxt;
			time_q     <= time_nxt;
			m100_q     <= m100_nxt;
			m400_q     <= m400_nxt;
		end
	end

endmodule

>>> hdl/ccds_disp.sv
// Digit select and seven-segment encode for the scanned display digit.
module ccds_disp (
	input  logic            show_hours,
	input  logic [1:0]      phase,
	input  ccds_pkg::time_t time_cur,
	output logic [7:0]      segments,
	output logic [3:0]      digit_enables
);

	logic [3:0] digit;

	always_comb begin
		case (phase)
			2'd0:    digit = show_hours ? {2'b00, time_cur.hr_t} : {1'b0, time_cur.min_t};
			2'd1:    digit = show_hours ? time_cur.hr_u : time_cur.min_u;
			2'd2:    digit = show_hours ? time_cur.min_u : time_cur.sec_u;
			default: digit = show_hours ? {1'b0, time_cur.min_t} : {1'b0, time_cur.sec_t};
		endcase
		segments      = ccds_pkg::seg_of(digit);
		digit_enables = ~(4'b0001 << phase);
	end

endmodule

>>> hdl/clock_calendar_with_display_scan_unit.sv
// Top level of the clock/calendar with multiplexed seven-segment display scan.
//
// Use: each request on the slave stream (s_*) is one display-scan timer tick,
// with s_tdata[0] selecting hours:minutes (1) or minutes:seconds (0). For each
// request one result leaves on the master stream (m_*): the segment pattern
// and active-low digit enable of the digit scanned on this tick (taken from
// the time before this tick's advance), then the time and date after it.
// Every second scan phase counts a half-tick; reaching counts_per_second
// advances the BCD time, rolling through day, month and year (Gregorian leap
// years, year held at 9999).
// counts_per_second is written over the cfg_* channel (always ready); write
// it only while no request is in flight.
// m_tvalid rises in the cycle after request acceptance. Throughput: one
// request per cycle, set by the single output register; s_tready stays high
// while that register is empty or being drained.
// Stall: with m_tvalid high and m_tready low the result holds and s_tready
// drops, so no request is lost.
// Reset (arst_n low): scan phase 0, time 00:00:00, 1 December 2018,
// counts_per_second 244, output empty.
module clock_calendar_with_display_scan_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] show_hours, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] segments, [11:8] digit_enables, [15:12] second_ones, [18:16] second_tens,
	// [22:19] minute_ones, [25:23] minute_tens, [29:26] hour_ones, [31:30] hour_tens,
	// [36:32] day_of_month, [40:37] month_number, [54:41] year_number, [55] zero
	output logic [55:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);

	logic [ccds_pkg::CPS_W-1:0] cps_q;
	logic                       accept;
	logic [1:0]                 phase_nxt;
	ccds_pkg::time_t            time_cur, time_nxt;
	logic [7:0]                 segments;
	logic [3:0]                 digit_enables;
	logic                       m_tvalid_q;
	logic [55:0]                m_tdata_q;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cps_q <= ccds_pkg::CPS_RESET;
		else if (cfg_valid && cfg_ready)
			cps_q <= cfg_data;
	end

	// take a request whenever the output register is free this cycle
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ccds_time_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (accept),
		.cps       (cps_q),
		.phase_nxt (phase_nxt),
		.time_cur  (time_cur),
		.time_nxt  (time_nxt)
	);

	// display uses the pre-advance time and the new phase
	ccds_disp u_disp (
		.show_hours    (s_tdata[0]),
		.phase         (phase_nxt),
		.time_cur      (time_cur),
		.segments      (segments),
		.digit_enables (digit_enables)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (accept)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			m_tdata_q <= {1'b0, time_nxt.year, time_nxt.month, time_nxt.day,
				time_nxt.hr_t, time_nxt.hr_u, time_nxt.min_t, time_nxt.min_u,
				time_nxt.sec_t, time_nxt.sec_u, digit_enables, segments};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hdl/ccds_checker.sv
// Port-level checker for the clock/calendar display scan unit, with its bind.
module ccds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// held result while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty output register never blocks a request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request blocked with output empty");

	// exactly one digit enable low
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(~m_tdata[11:8]))
		else $error("digit enables not one-cold");

	// BCD and calendar fields stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] <= 4'd9) && (m_tdata[18:16] <= 3'd5) &&
			(m_tdata[22:19] <= 4'd9) && (m_tdata[25:23] <= 3'd5) &&
			(m_tdata[36:32] != 5'd0) && (m_tdata[40:37] != 4'd0) &&
			(m_tdata[40:37] <= 4'd12) && (m_tdata[54:41] <= 14'd9999))
		else $error("time or date field out of range");

endmodule

bind clock_calendar_with_display_scan_unit ccds_checker u_ccds_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> bench/clock_calendar_with_display_scan_unit_test.sv
// Self-checking bench for the clock/calendar display scan unit: ticks, rate changes and rollovers.
`timescale 1ns / 1ps

module clock_calendar_with_display_scan_unit_test;

	// m_tdata layout, highest field first
	typedef struct packed {
		logic        pad;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [1:0]  hr_t;
		logic [3:0]  hr_u;
		logic [2:0]  min_t;
		logic [3:0]  min_u;
		logic [2:0]  sec_t;
		logic [3:0]  sec_u;
		logic [3:0]  dig_en;
		logic [7:0]  seg;
	} tick_result_t;

	localparam logic [7:0] SEG_CODE [10] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE4, 8'hFE, 8'hF6
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;    // [0] show_hours, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] segments, [11:8] digit_enables, [15:12] second_ones, [18:16] second_tens,
	// [22:19] minute_ones, [25:23] minute_tens, [29:26] hour_ones, [31:30] hour_tens,
	// [36:32] day_of_month, [40:37] month_number, [54:41] year_number, [55] zero
	logic [55:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [11:0] cfg_data = 12'd0;

	// predictor state
	logic [1:0]                 scan_phase = 2'd0;
	logic [ccds_pkg::CPS_W-1:0] half_ticks = '0;
	logic [ccds_pkg::CPS_W-1:0] rate = ccds_pkg::CPS_RESET;
	ccds_pkg::time_t            clock_now = ccds_pkg::TIME_RESET;

	tick_result_t pending_ticks [$];
	int unsigned  mismatches = 0;
	bit           gaps_on = 1'b1;

	clock_calendar_with_display_scan_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
		return (digit < 4'd10) ? SEG_CODE[digit] : 8'h00;
	endfunction

	function automatic int month_length(input logic [3:0] month, input logic [13:0] year);
		int  y;
		bit  leap;
		y = int'(year);
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (month == ccds_pkg::MONTH_FEB)
			return leap ? 29 : 28;
		if (month == ccds_pkg::MONTH_APR || month == ccds_pkg::MONTH_JUN ||
				month == ccds_pkg::MONTH_SEP || month == ccds_pkg::MONTH_NOV)
			return 30;
		return 31;
	endfunction

	// day, month and year carry at midnight
	function automatic void next_day();
		if (int'(clock_now.day) < month_length(clock_now.month, clock_now.year)) begin
			clock_now.day++;
			return;
		end
		clock_now.day = 5'd1;
		if (clock_now.month < ccds_pkg::MONTH_DEC) begin
			clock_now.month++;
			return;
		end
		clock_now.month = ccds_pkg::MONTH_JAN;
		if (clock_now.year < ccds_pkg::YEAR_MAX)
			clock_now.year++;
	endfunction

	// BCD ripple from seconds up to hours; 24:00 folds to 00:00
	function automatic void next_second();
		if (clock_now.sec_u < 4'd9) begin
			clock_now.sec_u++;
			return;
		end
		clock_now.sec_u = 4'd0;
		if (clock_now.sec_t < 3'd5) begin
			clock_now.sec_t++;
			return;
		end
		clock_now.sec_t = 3'd0;
		if (clock_now.min_u < 4'd9) begin
			clock_now.min_u++;
			return;
		end
		clock_now.min_u = 4'd0;
		if (clock_now.min_t < 3'd5) begin
			clock_now.min_t++;
			return;
		end
		clock_now.min_t = 3'd0;
		if (clock_now.hr_u == 4'd9) begin
			clock_now.hr_u = 4'd0;
			clock_now.hr_t++;
		end else begin
			clock_now.hr_u++;
		end
		if (clock_now.hr_t == 2'd2 && clock_now.hr_u == 4'd4) begin
			clock_now.hr_t = 2'd0;
			clock_now.hr_u = 4'd0;
			next_day();
		end
	endfunction

	// one accepted tick: scan digit from the old time, then the time advance
	function automatic tick_result_t predict_tick(input logic show_hours);
		tick_result_t r;
		logic [3:0]   digit;
		scan_phase = scan_phase + 2'd1;
		case (scan_phase)
			2'd0: digit = show_hours ? {2'b00, clock_now.hr_t} : {1'b0, clock_now.min_t};
			2'd1: digit = show_hours ? clock_now.hr_u : clock_now.min_u;
			2'd2: digit = show_hours ? clock_now.min_u : clock_now.sec_u;
			default: digit = show_hours ? {1'b0, clock_now.min_t} : {1'b0, clock_now.sec_t};
		endcase
		r.pad    = 1'b0;
		r.seg    = digit_pattern(digit);
		r.dig_en = ~(4'b0001 << scan_phase);
		// phases 0 and 2 count; >= so a lowered rate fires at once
		if (!scan_phase[0]) begin
			half_ticks = half_ticks + {{(ccds_pkg::CPS_W-1){1'b0}}, 1'b1};
			if (half_ticks >= rate) begin
				half_ticks = '0;
				next_second();
			end
		end
		r.sec_u = clock_now.sec_u;
		r.sec_t = clock_now.sec_t;
		r.min_u = clock_now.min_u;
		r.min_t = clock_now.min_t;
		r.hr_u  = clock_now.hr_u;
		r.hr_t  = clock_now.hr_t;
		r.day   = clock_now.day;
		r.month = clock_now.month;
		r.year  = clock_now.year;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result side: random back-pressure unless gaps are switched off
	always @(negedge clk)
		m_tready <= !gaps_on || ($urandom_range(99) >= 32);

	always @(posedge clk) begin
		tick_result_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_ticks.size() == 0) begin
				$error("result 0x%014h with no request outstanding", m_tdata);
				mismatches++;
			end else begin
				want = pending_ticks.pop_front();
				check_field("segments", want.seg, got.seg);
				check_field("digit_enables", want.dig_en, got.dig_en);
				check_field("second_ones", want.sec_u, got.sec_u);
				check_field("second_tens", want.sec_t, got.sec_t);
				check_field("minute_ones", want.min_u, got.min_u);
				check_field("minute_tens", want.min_t, got.min_t);
				check_field("hour_ones", want.hr_u, got.hr_u);
				check_field("hour_tens", want.hr_t, got.hr_t);
				check_field("day_of_month", want.day, got.day);
				check_field("month_number", want.month, got.month);
				check_field("year_number", want.year, got.year);
				check_field("pad", want.pad, got.pad);
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// entered and left at a falling edge; valid stays up for a following request
	task automatic send_tick(input logic show_hours);
		while (gaps_on && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, show_hours};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_ticks.push_back(predict_tick(show_hours));
		@(negedge clk);
	endtask

	// stop sending and let every outstanding result arrive
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_rate(input logic [ccds_pkg::CPS_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		rate = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	// reset date and rate; every scan phase in both display modes
	task automatic test_reset_scan();
		repeat (4) send_tick(1'b0);
		repeat (4) send_tick(1'b1);
	endtask

	// rate 0 and rate 1: every counting tick moves the seconds on
	task automatic test_fast_rates();
		write_rate('0);
		repeat (4) send_tick(1'($urandom_range(1)));
		write_rate(12'd1);
		repeat (4) send_tick(1'($urandom_range(1)));
	endtask

	// top rate, then a value below the running count fires on the next counting tick
	task automatic test_lowered_rate();
		write_rate(12'hFFF);
		repeat (4) send_tick(1'($urandom_range(1)));
		write_rate(12'd1);
		repeat (2) send_tick(1'($urandom_range(1)));
	endtask

	// random modes across several rates, one stretch without gaps, one mid-run pause
	task automatic test_random_ticks();
		logic [ccds_pkg::CPS_W-1:0] rates [5];
		rates[0] = 12'd1;
		rates[1] = 12'($urandom_range(30, 2));
		rates[2] = 12'($urandom_range(4095));
		rates[3] = 12'hFFF;
		rates[4] = ccds_pkg::CPS_RESET;
		for (int p = 0; p < 5; p++) begin
			write_rate(rates[p]);
			gaps_on = (p != 1);
			for (int i = 0; i < 260; i++) begin
				if (p == 2 && i == 130)
					drain();
				send_tick(1'($urandom_range(1)));
			end
		end
		gaps_on = 1'b1;
	endtask

	// fastest rate until the minute moves on: seconds carry into the minutes
	task automatic test_minute_carry();
		logic [3:0] start_min;
		write_rate(12'd1);
		start_min = clock_now.min_u;
		while (clock_now.min_u == start_min)
			send_tick(1'($urandom_range(1)));
		repeat (40) send_tick(1'($urandom_range(1)));
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_scan();
		test_fast_rates();
		test_lowered_rate();
		test_random_ticks();
		test_minute_carry();

		drain();
		repeat (8) @(negedge clk);
		if (pending_ticks.size() != 0) begin
			$error("%0d results never arrived", pending_ticks.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog: well beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/ccds_pkg.sv
hdl/ccds_time_core.sv
hdl/ccds_disp.sv
hdl/clock_calendar_with_display_scan_unit.sv
hdl/ccds_checker.sv
bench/clock_calendar_with_display_scan_unit_test.sv
